// File: rtl/core/trd_pkg.sv
package trd_pkg;

    // Storage kept for the earlier bytes of a pixel; bytes beyond it read as zero
    localparam int PIXEL_BITS = 24;

    localparam int BYTE_W     = 8;
    localparam int REP_W      = 8;
    localparam int COUNT_W    = 25;
    localparam int BPP_W      = 3;
    localparam int SLOT_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 25;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMPRESSED      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREYSCALE       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_TOTAL     = 2'd3;

    // Packet header decoding
    localparam logic [BYTE_W-1:0] RUN_HEADER_MIN = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS       = 8'd127;
    localparam logic [REP_W-1:0]  PACKET_MAX     = 8'd128;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'd255;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RAW    = 3'b010,
        PH_RUN    = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic               compressed;
        logic               greyscale;
        logic [COUNT_W-1:0] pixel_total;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [REP_W-1:0]  repeat_res;
        logic              image_end;
    } pixel_t;

endpackage

// File: rtl/core/trd_cfg_regs.sv
module trd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [trd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
    output trd_pkg::cfg_t                  cfg
);
    import trd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_addr)
                CFG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_data[BPP_W-1:0];
                CFG_COMPRESSED:      cfg_next.compressed      = cfg_data[0];
                CFG_GREYSCALE:       cfg_next.greyscale       = cfg_data[0];
                CFG_PIXEL_TOTAL:     cfg_next.pixel_total     = cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel <= BPP_W'(4);
            cfg_reg.compressed      <= 1'b1;
            cfg_reg.greyscale       <= 1'b0;
            cfg_reg.pixel_total     <= COUNT_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/trd_decode.sv
module trd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  trd_pkg::cfg_t              cfg,
    input  logic                       accept,
    input  logic [trd_pkg::BYTE_W-1:0] in_byte,
    output logic                       res_valid,
    output trd_pkg::pixel_t            res
);
    import trd_pkg::*;

    phase_t               phase_reg,       phase_next;
    logic [REP_W-1:0]     packet_left_reg, packet_left_next;
    logic [SLOT_W-1:0]    byte_slot_reg,   byte_slot_next;
    logic [PIXEL_BITS-1:0] pixel_bytes_reg, pixel_bytes_next;
    logic [COUNT_W-1:0]   pixels_left_reg, pixels_left_next;

    logic [BPP_W-1:0]     bpp_eff;
    logic                 done;
    logic [SLOT_W-1:0]    slot_gather;
    logic [PIXEL_BITS-1:0] bytes_gather;
    logic [31:0]          stored_wide;
    logic [31:0]          insert_wide;
    logic [BYTE_W-1:0]    b [4];
    logic [COUNT_W-1:0]   total_load;
    logic [COUNT_W-1:0]   pl_cur;
    logic [REP_W-1:0]     rep;
    logic [REP_W-1:0]     run_rep;
    logic                 emit;
    logic [COUNT_W-1:0]   rep_wide;
    logic [COUNT_W-1:0]   pl_after;

    // Normalize the pixel size to 1, 3 or 4 bytes
    always_comb
    begin
        if (cfg.bytes_per_pixel <= BPP_W'(1))
            bpp_eff = BPP_W'(1);
        else if (cfg.bytes_per_pixel <= BPP_W'(3))
            bpp_eff = BPP_W'(3);
        else
            bpp_eff = BPP_W'(4);
    end

    assign total_load = (cfg.pixel_total != '0) ? cfg.pixel_total : COUNT_W'(1);

    // Gather one byte into the pixel under assembly
    always_comb
    begin
        stored_wide = 32'(pixel_bytes_reg);
        insert_wide = 32'(in_byte) << {byte_slot_reg, 3'b000};
        done        = ({1'b0, byte_slot_reg} + BPP_W'(1)) >= bpp_eff;
        for (int k = 0; k < 4; k++)
            b[k] = stored_wide[8*k +: 8];
        b[byte_slot_reg] = in_byte;
        if (done)
        begin
            slot_gather  = '0;
            bytes_gather = '0;
        end
        else
        begin
            slot_gather  = byte_slot_reg + SLOT_W'(1);
            bytes_gather = PIXEL_BITS'(stored_wide | insert_wide);
        end
    end

    // Run length from a run header, clipped to the pixels left
    always_comb
    begin
        run_rep = in_byte - RUN_BIAS;
        if (COUNT_W'(run_rep) > pl_cur)
            run_rep = pl_cur[REP_W-1:0];
    end

    // Step the packet state for one byte
    always_comb
    begin
        phase_next       = phase_reg;
        packet_left_next = packet_left_reg;
        byte_slot_next   = byte_slot_reg;
        pixel_bytes_next = pixel_bytes_reg;
        pl_cur           = pixels_left_reg;
        rep              = REP_W'(1);
        emit             = 1'b0;

        if (!cfg.compressed)
        begin
            if (byte_slot_reg == '0 && pixels_left_reg == '0)
                pl_cur = total_load;
            byte_slot_next   = slot_gather;
            pixel_bytes_next = bytes_gather;
            emit             = done && (pl_cur != '0);
        end
        else
        begin
            unique case (phase_reg)
                PH_RAW:
                begin
                    byte_slot_next   = slot_gather;
                    pixel_bytes_next = bytes_gather;
                    if (done)
                    begin
                        if (packet_left_reg > '0)
                            packet_left_next = packet_left_reg - REP_W'(1);
                        if (packet_left_reg <= REP_W'(1))
                            phase_next = PH_HEADER;
                        emit = (pl_cur != '0);
                    end
                end
                PH_RUN:
                begin
                    byte_slot_next   = slot_gather;
                    pixel_bytes_next = bytes_gather;
                    if (done)
                    begin
                        phase_next       = PH_HEADER;
                        rep              = packet_left_reg;
                        packet_left_next = '0;
                        emit = (packet_left_reg != '0) && (pl_cur != '0);
                    end
                end
                default:
                begin
                    if (pixels_left_reg == '0)
                        pl_cur = total_load;
                    byte_slot_next   = '0;
                    pixel_bytes_next = '0;
                    if (in_byte < RUN_HEADER_MIN)
                    begin
                        packet_left_next = in_byte + REP_W'(1);
                        phase_next       = PH_RAW;
                    end
                    else
                    begin
                        packet_left_next = run_rep;
                        phase_next       = PH_RUN;
                    end
                end
            endcase
        end
    end

    // Count down the image and format the pixel
    always_comb
    begin
        rep_wide = COUNT_W'(rep);
        pl_after = (pl_cur >= rep_wide) ? pl_cur - rep_wide : '0;
        pixels_left_next = emit ? pl_after : pl_cur;

        res.red        = b[0];
        res.green      = b[0];
        res.blue       = b[0];
        res.alpha      = ALPHA_OPAQUE;
        if (!cfg.greyscale && bpp_eff >= BPP_W'(3))
        begin
            res.red   = b[2];
            res.green = b[1];
            res.blue  = b[0];
            if (bpp_eff == BPP_W'(4))
                res.alpha = b[3];
        end
        res.repeat_res = rep;
        res.image_end  = (pl_after == '0);
        res_valid      = accept && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            packet_left_reg <= '0;
            byte_slot_reg   <= '0;
            pixel_bytes_reg <= '0;
            pixels_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            packet_left_reg <= packet_left_next;
            byte_slot_reg   <= byte_slot_next;
            pixel_bytes_reg <= pixel_bytes_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

    // A pending run always holds between 1 and 128 copies
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RUN |-> packet_left_reg != '0 && packet_left_reg <= PACKET_MAX)
        else $error("run packet length out of range");

    // A result never repeats zero times or more than a packet allows
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.repeat_res != '0 && res.repeat_res <= PACKET_MAX)
        else $error("result repeat count out of range");

endmodule

// File: rtl/core/trd_out_buf.sv
module trd_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  trd_pkg::pixel_t push_data,
    input  logic            out_stall,
    output logic            out_valid,
    output trd_pkg::pixel_t out_data,
    output logic            full
);
    import trd_pkg::*;

    logic   main_valid_reg, main_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    pixel_t main_reg,       main_next;
    pixel_t skid_reg,       skid_next;
    logic   pop;

    assign pop = main_valid_reg && !out_stall;

    // Move requests between the output register and the skid slot
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign full      = skid_valid_reg;

    // The skid slot only fills behind a waiting output
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot holds a request with the output register empty");

    // No request arrives while both slots are taken
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("request pushed into a full output buffer");

    // A request waiting in the skid slot moves up as soon as the output drains
    a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg)
        else $error("skid request lost on output drain");

endmodule

// File: rtl/core/tga_rle_pixel_decoder_unit.sv
// TGA run-length pixel decoder.
// Input channel: one byte of image pixel data per request (in_valid, in_stall,
// in_byte). Output channel: one decoded pixel per request with its repeat
// count and an end-of-image flag (out_valid, out_stall, red..image_end).
// Configuration: cfg_write with cfg_addr selects bytes_per_pixel, compressed,
// greyscale or pixel_total; write only while no byte is in flight.
// Each byte is decoded in the cycle it is accepted; a pixel completed by that
// byte is registered into the output buffer. Throughput is one byte per cycle
// while in_stall is low.
// Packet headers and the non-final bytes of a pixel give no output request.
// A two-entry output buffer (register plus skid slot) keeps bytes flowing
// while the receiver stalls; in_stall rises only when both entries are full
// and falls the cycle after the receiver takes a pixel.
// Reset returns the configuration to 4 bytes per pixel, compressed, colour,
// one pixel, and puts the decoder at a packet header with no image loaded;
// the next image starts on the first byte after that.
module tga_rle_pixel_decoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [trd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [trd_pkg::BYTE_W-1:0]     in_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [trd_pkg::BYTE_W-1:0]     red,
    output logic [trd_pkg::BYTE_W-1:0]     green,
    output logic [trd_pkg::BYTE_W-1:0]     blue,
    output logic [trd_pkg::BYTE_W-1:0]     alpha,
    output logic [trd_pkg::REP_W-1:0]      repeat_res,
    output logic                           image_end
);
    import trd_pkg::*;

    cfg_t   cfg;
    logic   accept;
    logic   res_valid;
    pixel_t res;
    pixel_t out_data;
    logic   buf_full;

    assign accept   = in_valid && !buf_full;
    assign in_stall = buf_full;

    trd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    trd_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign red        = out_data.red;
    assign green      = out_data.green;
    assign blue       = out_data.blue;
    assign alpha      = out_data.alpha;
    assign repeat_res = out_data.repeat_res;
    assign image_end  = out_data.image_end;

endmodule

// File: bench/tga_pixel_checker.sv
module tga_pixel_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [trd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [trd_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [trd_pkg::BYTE_W-1:0]     red,
    input  logic [trd_pkg::BYTE_W-1:0]     green,
    input  logic [trd_pkg::BYTE_W-1:0]     blue,
    input  logic [trd_pkg::BYTE_W-1:0]     alpha,
    input  logic [trd_pkg::REP_W-1:0]      repeat_res,
    input  logic                           image_end,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import trd_pkg::*;

    localparam logic [31:0] HELD_MASK = 32'((64'd1 << PIXEL_BITS) - 64'd1);
    localparam int          MAX_PRINTS = 40;

    // Shadow copy of the configuration registers
    logic [BPP_W-1:0]   bpp_reg;
    logic               comp_reg;
    logic               grey_reg;
    logic [COUNT_W-1:0] total_reg;

    // Decoder state as the predictor tracks it
    phase_t             pkt_phase;
    logic [REP_W-1:0]   pkt_left;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        held;
    logic [COUNT_W-1:0] remaining;

    // Pixels predicted but not yet seen on the output
    pixel_t             pixel_q[$];
    pixel_t             want_px;
    int                 pixel_no;

    function automatic int unsigned pix_size();
        if (bpp_reg <= 3'd1)
            return 1;
        if (bpp_reg <= 3'd3)
            return 3;
        return 4;
    endfunction

    function automatic void load_image();
        remaining = (total_reg != '0) ? total_reg : 25'd1;
    endfunction

    // Add one byte to the pixel under assembly; report when it completes
    function automatic bit gather(input logic [7:0] b, output logic [31:0] px);
        int unsigned n;
        n = pix_size();
        px = '0;
        if (int'(slot) + 1 >= int'(n))
        begin
            px = held;
            px[8*slot +: 8] = b;
            slot = '0;
            held = '0;
            return 1'b1;
        end
        held = (held | (32'(b) << (8 * slot))) & HELD_MASK;
        slot = slot + 2'd1;
        return 1'b0;
    endfunction

    // Swap BGR to RGB, fill alpha and count the pixels off the image
    function automatic pixel_t make_pixel(input logic [31:0] px, input logic [7:0] rep);
        pixel_t      p;
        int unsigned n;
        n = pix_size();
        p.red   = px[7:0];
        p.green = px[7:0];
        p.blue  = px[7:0];
        p.alpha = ALPHA_OPAQUE;
        if (!grey_reg && n >= 3)
        begin
            p.red   = px[23:16];
            p.green = px[15:8];
            p.blue  = px[7:0];
            if (n == 4)
                p.alpha = px[31:24];
        end
        remaining = (remaining >= 25'(rep)) ? remaining - 25'(rep) : '0;
        p.repeat_res = rep;
        p.image_end  = (remaining == '0);
        return p;
    endfunction

    // Queue a predicted pixel behind those still waiting
    function automatic void enqueue_pixel(input pixel_t p);
        pixel_q.insert(pixel_q.size(), p);
    endfunction

    // Advance the decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] b);
        logic [31:0]        px;
        logic [COUNT_W-1:0] rep;
        bit                 done;
        if (!comp_reg)
        begin
            if (slot == '0 && remaining == '0)
                load_image();
            done = gather(b, px);
            if (done && remaining != '0)
                enqueue_pixel(make_pixel(px, 8'd1));
        end
        else
        begin
            case (pkt_phase)
                PH_RAW:
                begin
                    done = gather(b, px);
                    if (done)
                    begin
                        if (pkt_left != '0)
                            pkt_left = pkt_left - 8'd1;
                        if (pkt_left == '0)
                            pkt_phase = PH_HEADER;
                        // drop raw pixels that run past the image
                        if (remaining != '0)
                            enqueue_pixel(make_pixel(px, 8'd1));
                    end
                end
                PH_RUN:
                begin
                    done = gather(b, px);
                    if (done)
                    begin
                        pkt_phase = PH_HEADER;
                        rep = 25'(pkt_left);
                        pkt_left = '0;
                        if (rep != '0 && remaining != '0)
                            enqueue_pixel(make_pixel(px, rep[7:0]));
                    end
                end
                default:
                begin
                    if (remaining == '0)
                        load_image();
                    slot = '0;
                    held = '0;
                    if (b < RUN_HEADER_MIN)
                    begin
                        pkt_left = b + 8'd1;
                        pkt_phase = PH_RAW;
                    end
                    else
                    begin
                        // clip the run to what is left of the image
                        rep = 25'(b) - 25'(RUN_BIAS);
                        if (rep > remaining)
                            rep = remaining;
                        pkt_left = rep[7:0];
                        pkt_phase = PH_RUN;
                    end
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("pixel %0d: %s got %0h expected %0h", pixel_no, what, got, want);
    endtask

    // Compare output requests, then predict from input requests, then track writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    = 3'd4;
            comp_reg   = 1'b1;
            grey_reg   = 1'b0;
            total_reg  = 25'd1;
            pkt_phase  = PH_HEADER;
            pkt_left   = '0;
            slot       = '0;
            held       = '0;
            remaining  = '0;
            pixel_no   = 0;
            fail_count = 0;
            pixel_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    report_mismatch("pixel with none pending",
                                    {red, green, blue, alpha, repeat_res, image_end}, '0);
                end
                else
                begin
                    want_px = pixel_q.pop_front();
                    if (red !== want_px.red)
                        report_mismatch("red", red, want_px.red);
                    if (green !== want_px.green)
                        report_mismatch("green", green, want_px.green);
                    if (blue !== want_px.blue)
                        report_mismatch("blue", blue, want_px.blue);
                    if (alpha !== want_px.alpha)
                        report_mismatch("alpha", alpha, want_px.alpha);
                    if (repeat_res !== want_px.repeat_res)
                        report_mismatch("repeat_res", repeat_res, want_px.repeat_res);
                    if (image_end !== want_px.image_end)
                        report_mismatch("image_end", image_end, want_px.image_end);
                end
                pixel_no++;
            end

            if (in_valid && !in_stall)
                decode_byte(in_byte);

            if (cfg_write)
            begin
                case (cfg_addr)
                    CFG_BYTES_PER_PIXEL: bpp_reg   = cfg_data[BPP_W-1:0];
                    CFG_COMPRESSED:      comp_reg  = cfg_data[0];
                    CFG_GREYSCALE:       grey_reg  = cfg_data[0];
                    CFG_PIXEL_TOTAL:     total_reg = cfg_data[COUNT_W-1:0];
                    default:             ;
                endcase
            end

            outstanding <= pixel_q.size();
        end
    end

endmodule

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int IMAGE_BUDGET = 64;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [BYTE_W-1:0]     in_byte   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [BYTE_W-1:0]     red;
    logic [BYTE_W-1:0]     green;
    logic [BYTE_W-1:0]     blue;
    logic [BYTE_W-1:0]     alpha;
    logic [REP_W-1:0]      repeat_res;
    logic                  image_end;

    int          fail_count;
    int          outstanding;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;
    int          cycles         = 0;
    logic [7:0]  burst_q[$];

    tga_rle_pixel_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .repeat_res (repeat_res),
        .image_end  (image_end)
    );

    tga_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .repeat_res  (repeat_res),
        .image_end   (image_end),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the output side at the current rate
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned bytes_in_pixel(input logic [2:0] v);
        if (v <= 3'd1)
            return 1;
        if (v <= 3'd3)
            return 3;
        return 4;
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_pixel(input int unsigned n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_burst();
        foreach (burst_q[i])
            send_byte(burst_q[i]);
        burst_q.delete();
    endtask

    // Drop valid, let pending pixels drain, then stay idle as long as drain asks
    task automatic wait_quiet(input int drain);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (drain) @(posedge clk);
    endtask

    // Write all four registers, sometimes with junk in the unused upper bits
    task automatic set_config(input logic [2:0] bpp, input logic comp, input logic grey,
                              input logic [24:0] total);
        logic [24:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? 25'($urandom) : '0;
        cfg_write <= 1'b1;
        cfg_addr  <= CFG_BYTES_PER_PIXEL;
        cfg_data  <= {junk[24:3], bpp};
        @(posedge clk);
        cfg_addr  <= CFG_COMPRESSED;
        cfg_data  <= {junk[24:1], comp};
        @(posedge clk);
        cfg_addr  <= CFG_GREYSCALE;
        cfg_data  <= {junk[24:1], grey};
        @(posedge clk);
        cfg_addr  <= CFG_PIXEL_TOTAL;
        cfg_data  <= total;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Send a well-formed image, cut short once its byte budget is spent
    task automatic send_image(input int unsigned n, input logic comp, input logic [24:0] total);
        int unsigned left;
        int unsigned cnt;
        int unsigned cap;
        int unsigned start;
        left  = (total == '0) ? 1 : int'(total);
        start = bytes_sent;
        while (left > 0 && bytes_sent - start < IMAGE_BUDGET)
        begin
            if (!comp)
            begin
                send_pixel(n);
                cnt = 1;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                // raw packet, now and then running past the image
                cap = (left < 16) ? left : 16;
                if (n == 1 && $urandom_range(0, 3) == 0)
                    cap = (left < 128) ? left : 128;
                cnt = $urandom_range(1, cap);
                if ($urandom_range(0, 9) == 0)
                    cnt = (cnt + 3 > 128) ? 128 : cnt + 3;
                send_byte(8'(cnt - 1));
                repeat (cnt) send_pixel(n);
            end
            else
            begin
                // run packet, sometimes longer than the image has left
                cap = (left < 128) ? left : 128;
                cnt = $urandom_range(1, cap);
                if ($urandom_range(0, 3) == 0)
                    cnt = $urandom_range(1, 128);
                send_byte(8'(cnt + 127));
                send_pixel(n);
            end
            left = (cnt >= left) ? 0 : left - cnt;
        end
    endtask

    initial
    begin
        int unsigned setting;
        int unsigned directed_sent;
        int unsigned pick;
        logic [2:0]  bpp;
        logic        comp;
        logic        grey;
        logic [24:0] total;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one raw pixel, then a run clipped to a one-pixel image
        burst_q = '{8'h00, 8'h00, 8'hFF, 8'hAA, 8'h55};
        send_burst();
        burst_q = '{8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
        send_burst();

        // Plain grey, zero pixel total
        wait_quiet(4);
        set_config(3'd1, 1'b0, 1'b1, 25'd0);
        send_byte(8'h80);

        // Two bytes per pixel taken as three: run then raw packet
        wait_quiet(4);
        set_config(3'd2, 1'b1, 1'b0, 25'd3);
        burst_q = '{8'h81, 8'h01, 8'h02, 8'h03, 8'h00, 8'hFE, 8'hDC, 8'hBA};
        send_burst();

        // Zero bytes per pixel; raw packet that runs past the image
        wait_quiet(4);
        set_config(3'd0, 1'b1, 1'b0, 25'd1);
        burst_q = '{8'h01, 8'hC3, 8'h3C};
        send_burst();

        // Pixel size shrinks in the middle of a pixel
        wait_quiet(4);
        set_config(3'd7, 1'b0, 1'b1, 25'd2);
        burst_q = '{8'hA5, 8'h5A};
        send_burst();
        wait_quiet(4);
        set_config(3'd1, 1'b0, 1'b1, 25'd2);
        burst_q = '{8'h0F, 8'hF0};
        send_burst();

        // Random settings, each with a few images or some noise
        directed_sent = bytes_sent;
        setting = 0;
        while (bytes_sent < directed_sent + RANDOM_ITEMS)
        begin
            wait_quiet(4);
            case (setting % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase

            bpp  = 3'($urandom_range(0, 7));
            comp = ($urandom_range(0, 9) < 7);
            grey = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       total = 25'd0;
                    1:       total = 25'd1;
                    2:       total = 25'd16777216;
                    default: total = 25'h1FFFFFF;
                endcase
            end
            else if (pick == 1)
                total = 25'($urandom);
            else
                total = 25'($urandom_range(1, 24));
            set_config(bpp, comp, grey, total);

            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 99) < 85)
                    send_image(bytes_in_pixel(bpp), comp, total);
                else
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            setting++;
        end

        // Drain and give the verdict
        wait_quiet(16);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
